// ===== design/cubic_bezier_point_generator_core_assert.svh =====
// ---------------------------------------------------------------------------
// cubic bezier point generator assertion macros
// shared property shapes for the port-level checker
// ---------------------------------------------------------------------------
`ifndef CUBIC_BEZIER_POINT_GENERATOR_CORE_ASSERT_SVH
`define CUBIC_BEZIER_POINT_GENERATOR_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define CBPG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("cbpg assertion failed");

// next-cycle implication, disabled during reset
`define CBPG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("cbpg assertion failed");

`endif

// ===== design/cbpg_pkg.sv =====
// ---------------------------------------------------------------------------
// cbpg_pkg
// shared constants for the cubic bezier point generator
// ---------------------------------------------------------------------------
package cbpg_pkg;

    // default configuration of the generator
    localparam int DEF_MAX_POINTS  = 64;
    localparam int DEF_COORD_BITS  = 10;

    // curve parameter u is q0.16
    localparam int U_FRAC          = 16;
    localparam int U_W             = U_FRAC + 1;
    localparam logic [U_W-1:0] U_ONE = U_W'(1) << U_FRAC;
    localparam logic [U_FRAC-1:0] U_STEP_RESET = 16'd3277;

    // output fixed point: 8 fraction bits out of a 2^48 scaled sum
    localparam int FRAC_OUT        = 8;
    localparam int SUM_SHIFT       = 3 * U_FRAC - FRAC_OUT;

    // point index field
    localparam int NUM_W           = 6;

endpackage

// ===== design/cubic_bezier_point_generator_core.sv =====
// ---------------------------------------------------------------------------
// cubic bezier point generator core
// emits the points of one cubic bezier curve per request item
// ---------------------------------------------------------------------------
// usage:
//   input channel  : i_valid / o_stall carries four 2-d control points; an
//                    item is taken when i_valid is high and o_stall is low
//   output channel : o_valid / i_stall carries one curve point per item:
//                    x and y in unsigned 10.8 (truncated), point index and
//                    a last flag on the final point of the curve
//   config         : i_cfg_we / i_cfg_wdata writes u_step (q0.16); the
//                    user must write it only while the block is idle,
//                    which the block itself does not enforce
// sequence: each point runs on the shared multiplier as 2 squares, 9 steps
//   per axis and 1 emit step; with the reset step a curve has 20 points
//   the block takes one request at a time; o_stall is high until the last
//   point sits in the output register
// reset: sequencer idle, output empty, u_step back to 3277
// receiver stall: the output register holds its point, computation of the
//   next point finishes and waits in the emit step until the slot frees
// ---------------------------------------------------------------------------
module cubic_bezier_point_generator_core
    import cbpg_pkg::*;
#(
    parameter int MAX_POINTS = DEF_MAX_POINTS,
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration
    input  logic                    i_cfg_we,
    input  logic [U_FRAC-1:0]       i_cfg_wdata,
    // request channel
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [COORD_BITS-1:0]   i_p0_x,
    input  logic [COORD_BITS-1:0]   i_p0_y,
    input  logic [COORD_BITS-1:0]   i_p1_x,
    input  logic [COORD_BITS-1:0]   i_p1_y,
    input  logic [COORD_BITS-1:0]   i_p2_x,
    input  logic [COORD_BITS-1:0]   i_p2_y,
    input  logic [COORD_BITS-1:0]   i_p3_x,
    input  logic [COORD_BITS-1:0]   i_p3_y,
    // point channel
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [COORD_BITS+7:0]   o_point_x,
    output logic [COORD_BITS+7:0]   o_point_y,
    output logic [NUM_W-1:0]        o_point_number,
    output logic                    o_last_point
);

    // operand widths: a*v + 3b*u stays below 2^(coord+18),
    // the full bernstein sum below 2^(coord+48)
    localparam int CW  = COORD_BITS;
    localparam int TW  = CW + 2;
    localparam int MW  = CW + 18;
    localparam int PW  = MW + U_W;
    localparam int SW  = CW + 3 * U_FRAC;
    localparam int OW  = CW + FRAC_OUT;
    localparam logic [NUM_W-1:0] LAST_IDX = NUM_W'(MAX_POINTS - 1);

    // one step per multiplier issue
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_VV,      // v*v
        ST_UU,      // u*u, latch v^2
        ST_AV,      // a*v, latch u^2 on the x axis
        ST_BU,      // 3b*u, t = a*v
        ST_CV,      // 3c*v, t += 3b*u
        ST_DU,      // d*u, w = 3c*v
        ST_TL,      // t*v2 low, w += d*u
        ST_TH,      // t*v2 high, acc = t*v2 low
        ST_WL,      // w*u2 low, acc += t*v2 high << 17
        ST_WH,      // w*u2 high, acc += w*u2 low
        ST_FIN,     // acc += w*u2 high << 17
        ST_EMIT     // wait for a free output slot
    } t_state;

    t_state r_state;

    logic [U_FRAC-1:0]  r_ustep;
    logic [U_FRAC-1:0]  r_u;
    logic [NUM_W-1:0]   r_cnt;
    logic               r_axis;     // 0: x, 1: y

    // latched control points, p1 and p2 kept tripled
    logic [CW-1:0]      r_pa  [2];
    logic [TW-1:0]      r_pb3 [2];
    logic [TW-1:0]      r_pc3 [2];
    logic [CW-1:0]      r_pd  [2];

    logic [PW-1:0]      r_prod;
    logic [2*U_FRAC:0]  r_v2;
    logic [2*U_FRAC-1:0] r_u2;
    logic [MW-1:0]      r_t;
    logic [MW-1:0]      r_w;
    logic [SW-1:0]      r_acc;
    logic [OW-1:0]      r_px;

    logic               r_ovalid;
    logic [OW-1:0]      r_ox;
    logic [OW-1:0]      r_oy;
    logic [NUM_W-1:0]   r_onum;
    logic               r_olast;

    logic [U_W-1:0]     u_ext;
    logic [U_W-1:0]     v_val;
    logic [MW-1:0]      mul_a;
    logic [U_W-1:0]     mul_b;
    logic [SW-1:0]      add_base;
    logic [SW-1:0]      addend;
    logic [SW-1:0]      sum;
    logic [SW-1:0]      prod_ext;
    logic [U_W-1:0]     n_u;
    logic               pt_last;
    logic               slot_free;
    logic               in_take;

    assign u_ext     = {1'b0, r_u};
    assign v_val     = U_ONE - u_ext;
    assign prod_ext  = SW'(r_prod);
    assign n_u       = u_ext + {1'b0, r_ustep};
    assign pt_last   = n_u[U_FRAC] || (r_cnt == LAST_IDX);
    assign slot_free = !r_ovalid || !i_stall;
    assign in_take   = i_valid && (r_state == ST_IDLE);

    // operand selection for the shared multiplier and accumulator adder
    always_comb begin
        mul_a    = '0;
        mul_b    = '0;
        add_base = '0;
        addend   = prod_ext;
        unique case (r_state)
            ST_VV: begin
                mul_a = MW'(v_val);
                mul_b = v_val;
            end
            ST_UU: begin
                mul_a = MW'(u_ext);
                mul_b = u_ext;
            end
            ST_AV: begin
                mul_a = MW'(r_pa[r_axis]);
                mul_b = v_val;
            end
            ST_BU: begin
                mul_a = MW'(r_pb3[r_axis]);
                mul_b = u_ext;
            end
            ST_CV: begin
                mul_a    = MW'(r_pc3[r_axis]);
                mul_b    = v_val;
                add_base = SW'(r_t);
            end
            ST_DU: begin
                mul_a = MW'(r_pd[r_axis]);
                mul_b = u_ext;
            end
            ST_TL: begin
                mul_a    = r_t;
                mul_b    = r_v2[U_W-1:0];
                add_base = SW'(r_w);
            end
            ST_TH: begin
                mul_a = r_t;
                mul_b = U_W'(r_v2[2*U_FRAC:U_W]);
            end
            ST_WL: begin
                mul_a    = r_w;
                mul_b    = r_u2[U_W-1:0];
                add_base = r_acc;
                addend   = prod_ext << U_W;
            end
            ST_WH: begin
                mul_a    = r_w;
                mul_b    = U_W'(r_u2[2*U_FRAC-1:U_W]);
                add_base = r_acc;
            end
            ST_FIN: begin
                add_base = r_acc;
                addend   = prod_ext << U_W;
            end
            default: begin
                mul_a    = '0;
                mul_b    = '0;
                add_base = '0;
            end
        endcase
    end

    assign sum = add_base + addend;

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= PW'(mul_a) * PW'(mul_b);
        if (in_take) begin
            r_pa[0]  <= i_p0_x;
            r_pa[1]  <= i_p0_y;
            r_pb3[0] <= TW'(i_p1_x) + (TW'(i_p1_x) << 1);
            r_pb3[1] <= TW'(i_p1_y) + (TW'(i_p1_y) << 1);
            r_pc3[0] <= TW'(i_p2_x) + (TW'(i_p2_x) << 1);
            r_pc3[1] <= TW'(i_p2_y) + (TW'(i_p2_y) << 1);
            r_pd[0]  <= i_p3_x;
            r_pd[1]  <= i_p3_y;
        end
        if (r_state == ST_UU) begin
            r_v2 <= r_prod[2*U_FRAC:0];
        end
        if (r_state == ST_AV && !r_axis) begin
            r_u2 <= r_prod[2*U_FRAC-1:0];
        end
        if (r_state == ST_BU) begin
            r_t <= prod_ext[MW-1:0];
        end
        if (r_state == ST_CV) begin
            r_t <= sum[MW-1:0];
        end
        if (r_state == ST_DU) begin
            r_w <= prod_ext[MW-1:0];
        end
        if (r_state == ST_TL) begin
            r_w <= sum[MW-1:0];
        end
        if (r_state == ST_TH) begin
            r_acc <= prod_ext;
        end
        if (r_state == ST_WL || r_state == ST_WH) begin
            r_acc <= sum;
        end
        if (r_state == ST_FIN) begin
            if (!r_axis) begin
                r_px <= sum[SW-1:SUM_SHIFT];
            end else begin
                r_acc <= sum;
            end
        end
    end

    // sequencer, configuration and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ustep  <= U_STEP_RESET;
            r_u      <= '0;
            r_cnt    <= '0;
            r_axis   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_ustep <= i_cfg_wdata;
            end
            // in the emit step a freed slot is refilled below
            if (r_ovalid && !i_stall && r_state != ST_EMIT) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_u     <= '0;
                        r_cnt   <= '0;
                        r_axis  <= 1'b0;
                        r_state <= ST_VV;
                    end
                end
                ST_VV:  r_state <= ST_UU;
                ST_UU:  r_state <= ST_AV;
                ST_AV:  r_state <= ST_BU;
                ST_BU:  r_state <= ST_CV;
                ST_CV:  r_state <= ST_DU;
                ST_DU:  r_state <= ST_TL;
                ST_TL:  r_state <= ST_TH;
                ST_TH:  r_state <= ST_WL;
                ST_WL:  r_state <= ST_WH;
                ST_WH:  r_state <= ST_FIN;
                ST_FIN: begin
                    if (!r_axis) begin
                        r_axis  <= 1'b1;
                        r_state <= ST_AV;
                    end else begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (slot_free) begin
                        r_ovalid <= 1'b1;
                        r_ox     <= r_px;
                        r_oy     <= r_acc[SW-1:SUM_SHIFT];
                        r_onum   <= r_cnt;
                        r_olast  <= pt_last;
                        r_axis   <= 1'b0;
                        if (pt_last) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_u     <= n_u[U_FRAC-1:0];
                            r_cnt   <= r_cnt + NUM_W'(1);
                            r_state <= ST_VV;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_stall        = (r_state != ST_IDLE);
    assign o_valid        = r_ovalid;
    assign o_point_x      = r_ox;
    assign o_point_y      = r_oy;
    assign o_point_number = r_onum;
    assign o_last_point   = r_olast;

endmodule

// ===== design/cbpg_checker.sv =====
// ---------------------------------------------------------------------------
// cbpg_checker
// port-level checks for the cubic bezier point generator
// ---------------------------------------------------------------------------
`include "cubic_bezier_point_generator_core_assert.svh"

module cbpg_checker
    import cbpg_pkg::*;
#(
    parameter int MAX_POINTS = DEF_MAX_POINTS,
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic                    o_stall,
    input  logic                    o_valid,
    input  logic                    i_stall,
    input  logic [COORD_BITS+7:0]   o_point_x,
    input  logic [COORD_BITS+7:0]   o_point_y,
    input  logic [NUM_W-1:0]        o_point_number,
    input  logic                    o_last_point
);

    localparam logic [NUM_W-1:0] LAST_IDX = NUM_W'(MAX_POINTS - 1);

    // a stalled point stays put
    `CBPG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_point_x) && $stable(o_point_y) && $stable(o_point_number) && $stable(o_last_point))

    // a taken request keeps the block busy
    `CBPG_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, i_valid && !o_stall, o_stall)

    // the point cap always closes the curve
    `CBPG_ASSERT_NOW(a_cap_is_last, i_clk, i_rst_n, o_valid && (o_point_number == LAST_IDX), o_last_point)

    // no point index beyond the cap
    `CBPG_ASSERT_NOW(a_index_in_range, i_clk, i_rst_n, o_valid, o_point_number <= LAST_IDX)

endmodule

bind cubic_bezier_point_generator_core cbpg_checker #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
) u_cbpg_checker (.*);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// curve requests in, bezier points out: a table of directed curves and then
// random curves across several u_step settings; every accepted point is
// compared field by field with a bit-exact bernstein predictor
// ---------------------------------------------------------------------------
module tb_top;
    import cbpg_pkg::*;

    localparam int COORD_W   = DEF_COORD_BITS;
    localparam int POINT_W   = DEF_COORD_BITS + FRAC_OUT;
    localparam int MAX_PTS   = DEF_MAX_POINTS;
    localparam int SETTLE    = 40;     // settle time, longer than one point takes
    localparam int HOLD_LONG = 600;    // long receiver hold-off
    localparam int IDLE_LIMIT = 3000;  // cycles with no item moving on either side

    typedef logic [COORD_W-1:0] t_coord;
    typedef logic [POINT_W-1:0] t_fix;

    typedef struct packed {
        t_coord p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y;
    } t_curve_req;

    typedef struct packed {
        t_fix             x;
        t_fix             y;
        logic [NUM_W-1:0] num;
        logic             last;
    } t_curve_point;

    // directed row: control points and, where every point of the curve is
    // obvious, the fixed x and y that each point must carry
    typedef struct packed {
        t_curve_req pts;
        logic       known;
        t_fix       fx;
        t_fix       fy;
    } t_curve_row;

    localparam int N_DIR = 13;
    localparam t_curve_row CURVE_TABLE [N_DIR] = '{
        // flat curves: all weights sum to one, so every point is c << 8
        '{'{10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0},
            1'b1, 18'd0, 18'd0},
        '{'{10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023,
            10'd1023, 10'd1023}, 1'b1, 18'd261888, 18'd261888},
        '{'{10'd512, 10'd512, 10'd512, 10'd512, 10'd512, 10'd512, 10'd512,
            10'd512}, 1'b1, 18'd131072, 18'd131072},
        '{'{10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1},
            1'b1, 18'd256, 18'd256},
        '{'{10'd1023, 10'd0, 10'd1023, 10'd0, 10'd1023, 10'd0, 10'd1023,
            10'd0}, 1'b1, 18'd261888, 18'd0},
        '{'{10'd0, 10'd1023, 10'd0, 10'd1023, 10'd0, 10'd1023, 10'd0,
            10'd1023}, 1'b1, 18'd0, 18'd261888},
        // one full-scale control point at a time
        '{'{10'd1023, 10'd1023, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0},
            1'b0, 18'd0, 18'd0},
        '{'{10'd0, 10'd0, 10'd1023, 10'd1023, 10'd0, 10'd0, 10'd0, 10'd0},
            1'b0, 18'd0, 18'd0},
        '{'{10'd0, 10'd0, 10'd0, 10'd0, 10'd1023, 10'd1023, 10'd0, 10'd0},
            1'b0, 18'd0, 18'd0},
        '{'{10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd1023, 10'd1023},
            1'b0, 18'd0, 18'd0},
        // s-shaped corner to corner
        '{'{10'd0, 10'd0, 10'd0, 10'd1023, 10'd1023, 10'd0, 10'd1023,
            10'd1023}, 1'b0, 18'd0, 18'd0},
        // alternating bit patterns
        '{'{10'd682, 10'd341, 10'd682, 10'd341, 10'd682, 10'd341, 10'd341,
            10'd682}, 1'b0, 18'd0, 18'd0},
        '{'{10'd341, 10'd682, 10'd341, 10'd682, 10'd341, 10'd682, 10'd682,
            10'd341}, 1'b0, 18'd0, 18'd0}
    };

    // u_step per phase; a negative entry means a random step is drawn
    localparam int N_PHASE = 12;
    localparam int PHASE_STEP  [N_PHASE] =
        '{65535, 0, 1024, 1, 16384, 32768, -1, -1, -1, -1, 2000, 3277};
    localparam int PHASE_ITEMS [N_PHASE] =
        '{40, 10, 12, 5, 30, 30, 25, 25, 25, 25, 20, 60};

    // clock, reset and block inputs, all known from time zero
    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic [U_FRAC-1:0] cfg_wdata = '0;
    logic             req_valid = 1'b0;
    t_curve_req       req_pts = '0;
    logic             pt_stall = 1'b0;

    logic             req_stall;
    logic             pt_valid;
    t_fix             pt_x;
    t_fix             pt_y;
    logic [NUM_W-1:0] pt_num;
    logic             pt_last;

    // testbench copy of the step register
    logic [U_FRAC-1:0] step_now = U_STEP_RESET;

    t_curve_point pending_points [$];
    int           mismatches = 0;
    bit           no_gaps = 1'b0;      // phases that run without idling
    bit           hold_points = 1'b0;  // asks the receiver for one long hold
    int           idle_cycles = 0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    cubic_bezier_point_generator_core i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata),
        .i_valid        (req_valid),
        .o_stall        (req_stall),
        .i_p0_x         (req_pts.p0_x),
        .i_p0_y         (req_pts.p0_y),
        .i_p1_x         (req_pts.p1_x),
        .i_p1_y         (req_pts.p1_y),
        .i_p2_x         (req_pts.p2_x),
        .i_p2_y         (req_pts.p2_y),
        .i_p3_x         (req_pts.p3_x),
        .i_p3_y         (req_pts.p3_y),
        .o_valid        (pt_valid),
        .i_stall        (pt_stall),
        .o_point_x      (pt_x),
        .o_point_y      (pt_y),
        .o_point_number (pt_num),
        .o_last_point   (pt_last)
    );

    // exact bernstein sum, weights scaled by 2^48, truncated to 8 fraction bits
    function automatic t_fix bernstein_point(t_coord a, t_coord b, t_coord c,
                                             t_coord d, logic [U_W-1:0] u);
        logic [63:0] uu, v, s;
        uu = 64'(u);
        v  = 64'(U_ONE) - uu;
        s  = 64'(a) * (v * v * v)
           + 64'(b) * (64'd3 * uu * v * v)
           + 64'(c) * (64'd3 * uu * uu * v)
           + 64'(d) * (uu * uu * uu);
        return t_fix'(s >> SUM_SHIFT);
    endfunction

    // queue every point one request yields under the current step
    task automatic predict_curve(t_curve_req r, logic known, t_fix fx, t_fix fy);
        logic [U_W-1:0] u;
        logic [31:0]    next;
        int             n;
        t_curve_point   p;
        u = '0;
        n = 0;
        while (u < U_ONE && n < MAX_PTS) begin
            next   = 32'(u) + 32'(step_now);
            p.last = (next >= 32'(U_ONE)) || (n + 1 >= MAX_PTS);
            p.x    = known ? fx : bernstein_point(r.p0_x, r.p1_x, r.p2_x, r.p3_x, u);
            p.y    = known ? fy : bernstein_point(r.p0_y, r.p1_y, r.p2_y, r.p3_y, u);
            p.num  = NUM_W'(n);
            pending_points.push_back(p);
            u = next[U_W-1:0];
            n++;
            if (p.last)
                break;
        end
    endtask

    function automatic int draw_gap();
        return no_gaps ? 0 : $urandom_range(0, 5);
    endfunction

    // extremes show up often, the rest is spread over the full range
    function automatic t_coord rand_coord();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return t_coord'($urandom_range(0, 1023));
        endcase
    endfunction

    function automatic t_curve_req rand_curve();
        t_curve_req r;
        r.p0_x = rand_coord();
        r.p0_y = rand_coord();
        r.p1_x = rand_coord();
        r.p1_y = rand_coord();
        r.p2_x = rand_coord();
        r.p2_y = rand_coord();
        r.p3_x = rand_coord();
        r.p3_y = rand_coord();
        return r;
    endfunction

    // offer one request; valid stays high across back-to-back items
    task automatic send_curve(t_curve_req r, logic known, t_fix fx, t_fix fy);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_pts   <= r;
        do @(posedge clk); while (req_stall !== 1'b0);
        predict_curve(r, known, fx, fy);
    endtask

    // write u_step once the block has drained
    task automatic write_step(logic [U_FRAC-1:0] s);
        req_valid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= s;
        @(posedge clk);
        cfg_we    <= 1'b0;
        step_now  = s;
    endtask

    function automatic void check_field(string name, int unsigned want,
                                        int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // stimulus: directed table at the reset step, then one phase per step
    initial begin
        int               s;
        logic [U_FRAC-1:0] step_pick;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIR; i++)
            send_curve(CURVE_TABLE[i].pts, CURVE_TABLE[i].known,
                       CURVE_TABLE[i].fx, CURVE_TABLE[i].fy);

        for (int ph = 0; ph < N_PHASE; ph++) begin
            s = PHASE_STEP[ph];
            if (s < 0)
                step_pick = (ph % 2 == 1) ? U_FRAC'($urandom_range(1024, 65535))
                                          : U_FRAC'($urandom_range(1024, 12000));
            else
                step_pick = U_FRAC'(s);
            write_step(step_pick);
            no_gaps = (ph % 4 == 1);
            // long receiver hold-off while requests keep coming in the last phase
            if (ph == N_PHASE - 1)
                hold_points = 1'b1;
            for (int k = 0; k < PHASE_ITEMS[ph]; k++)
                send_curve(rand_curve(), 1'b0, '0, '0);
        end

        req_valid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // point receiver: random stall before each point, one long hold on request
    initial begin
        int           wait_cycles;
        t_curve_point want;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            wait_cycles = draw_gap();
            if (hold_points) begin
                hold_points = 1'b0;
                wait_cycles = HOLD_LONG;
            end
            if (wait_cycles > 0) begin
                pt_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
            end
            pt_stall <= 1'b0;
            do @(posedge clk); while (pt_valid !== 1'b1);
            if (pending_points.size() == 0) begin
                $error("unexpected point: x %0d y %0d number %0d last %0d",
                       pt_x, pt_y, pt_num, pt_last);
                mismatches++;
            end else begin
                want = pending_points.pop_front();
                check_field("point_x", 32'(want.x), 32'(pt_x));
                check_field("point_y", 32'(want.y), 32'(pt_y));
                check_field("point_number", 32'(want.num), 32'(pt_num));
                check_field("last_point", 32'(want.last), 32'(pt_last));
            end
        end
    end

    // watchdog: ends the run when nothing moves for too long
    always @(posedge clk) begin
        if (rst_n) begin
            if ((req_valid === 1'b1 && req_stall === 1'b0) ||
                (pt_valid === 1'b1 && pt_stall === 1'b0))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

endmodule
